/* design/assert_macros.svh */
// Assertion helpers shared by the design files.
// Every check is sampled on the rising edge of clk and is off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// If the antecedent holds at an edge, the consequent must hold at the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/atrtpm_pkg.sv */
`default_nettype none

package atrtpm_pkg;

	// Command codes of an input item.
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_BYTE  = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	// Outcome codes of a result item.
	localparam logic [2:0] OUT_MATCHED      = 3'd0;
	localparam logic [2:0] OUT_FULL_TIMEOUT = 3'd1;
	localparam logic [2:0] OUT_CHAR_TIMEOUT = 3'd2;
	localparam logic [2:0] OUT_RING         = 3'd3;
	localparam logic [2:0] OUT_NO_CARRIER   = 3'd4;

	// Configuration register indexes.
	localparam logic [2:0] REG_FIRST_PATTERN  = 3'd0;
	localparam logic [2:0] REG_FIRST_LENGTH   = 3'd1;
	localparam logic [2:0] REG_SECOND_PATTERN = 3'd2;
	localparam logic [2:0] REG_SECOND_LENGTH  = 3'd3;
	localparam logic [2:0] REG_FULL_TIMEOUT   = 3'd4;
	localparam logic [2:0] REG_CHAR_TIMEOUT   = 3'd5;
	localparam logic [2:0] REG_EVENTS_ENABLE  = 3'd6;

	// Register reset values.
	localparam logic [3:0]  FIRST_LENGTH_RST  = 4'd2;
	localparam logic [3:0]  SECOND_LENGTH_RST = 4'd0;
	localparam logic [31:0] FULL_TIMEOUT_RST  = 32'd1000;
	localparam logic [31:0] CHAR_TIMEOUT_RST  = 32'd100;

	localparam int MAX_PATTERN_BYTES_DEF = 8;

	// Fixed unsolicited response texts.
	localparam logic [2:0] RING_LEN    = 3'd4;
	localparam logic [3:0] CARRIER_LEN = 4'd10;

	function automatic logic [7:0] ring_char(input logic [1:0] pos);
		logic [7:0] ch;
		case (pos)
			2'd0:    ch = 8'h52; // R
			2'd1:    ch = 8'h49; // I
			2'd2:    ch = 8'h4E; // N
			default: ch = 8'h47; // G
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] carrier_char(input logic [3:0] pos);
		logic [7:0] ch;
		case (pos)
			4'd0:    ch = 8'h4E; // N
			4'd1:    ch = 8'h4F; // O
			4'd2:    ch = 8'h20; // space
			4'd3:    ch = 8'h43; // C
			4'd4:    ch = 8'h41; // A
			4'd5:    ch = 8'h52; // R
			4'd6:    ch = 8'h52; // R
			4'd7:    ch = 8'h49; // I
			4'd8:    ch = 8'h45; // E
			4'd9:    ch = 8'h52; // R
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

/* design/at_response_two_pattern_matcher.sv */
// An accepted input item is held in the input register; its result item is loaded into the
// result register. Throughput: one input item per cycle while the input does not stall; the
// input register feeds one pass of logic into the result register, and the session state is
// updated in that same pass. The input side stalls only while a result item waits under
// result_stall and another is held. Reset (arst_n low, asynchronous): registers take their
// documented reset values and any session is dropped; no result is pending afterwards.
`default_nettype none
`include "assert_macros.svh"

module at_response_two_pattern_matcher #(
	parameter int MAX_PATTERN_BYTES = atrtpm_pkg::MAX_PATTERN_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	// Input item channel
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [1:0]  cmd,
	input  wire logic [7:0]  rx_byte,
	// Result item channel
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [2:0]       outcome
);

	// Longest pattern that the cursors compare; longer lengths are clipped to it.
	localparam logic [3:0] MAX_LEN = 4'(MAX_PATTERN_BYTES);

	// ------------------------------------------------------------------
	// Configuration registers. Writes are to be issued only while the block is idle; the
	// block itself does not enforce this. The port is always ready and has no hazard check.
	// ------------------------------------------------------------------
	logic [63:0] first_pattern_q;
	logic [3:0]  first_length_q;
	logic [63:0] second_pattern_q;
	logic [3:0]  second_length_q;
	logic [31:0] full_timeout_q;
	logic [31:0] char_timeout_q;
	logic        events_enable_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_pattern_q  <= '0;
			first_length_q   <= atrtpm_pkg::FIRST_LENGTH_RST;
			second_pattern_q <= '0;
			second_length_q  <= atrtpm_pkg::SECOND_LENGTH_RST;
			full_timeout_q   <= atrtpm_pkg::FULL_TIMEOUT_RST;
			char_timeout_q   <= atrtpm_pkg::CHAR_TIMEOUT_RST;
			events_enable_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				atrtpm_pkg::REG_FIRST_PATTERN:  first_pattern_q  <= cfg_data;
				atrtpm_pkg::REG_FIRST_LENGTH:   first_length_q   <= cfg_data[3:0];
				atrtpm_pkg::REG_SECOND_PATTERN: second_pattern_q <= cfg_data;
				atrtpm_pkg::REG_SECOND_LENGTH:  second_length_q  <= cfg_data[3:0];
				atrtpm_pkg::REG_FULL_TIMEOUT:   full_timeout_q   <= cfg_data[31:0];
				atrtpm_pkg::REG_CHAR_TIMEOUT:   char_timeout_q   <= cfg_data[31:0];
				atrtpm_pkg::REG_EVENTS_ENABLE:  events_enable_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Effective pattern lengths after clipping to the compare window.
	logic [3:0] flen;
	logic [3:0] slen;
	assign flen = (first_length_q > MAX_LEN) ? MAX_LEN : first_length_q;
	assign slen = (second_length_q > MAX_LEN) ? MAX_LEN : second_length_q;

	// ------------------------------------------------------------------
	// Input register. An item moves on (is processed) whenever the result
	// register is empty or is being taken in the same cycle.
	// ------------------------------------------------------------------
	logic       valid_s1;
	logic [1:0] cmd_s1;
	logic [7:0] rx_byte_s1;
	logic       result_valid_q;
	logic [2:0] outcome_q;
	logic       go;

	assign go         = valid_s1 && !(result_valid_q && result_stall);
	assign item_stall = valid_s1 && result_valid_q && result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			cmd_s1     <= cmd;
			rx_byte_s1 <= rx_byte;
		end
	end

	// ------------------------------------------------------------------
	// Session state.
	// ------------------------------------------------------------------
	logic        active_q;
	logic [3:0]  first_cursor_q;
	logic        first_found_q;
	logic [3:0]  second_cursor_q;
	logic [2:0]  ring_cursor_q;
	logic [3:0]  carrier_cursor_q;
	logic [31:0] elapsed_ticks_q;
	logic [31:0] idle_ticks_q;
	logic        byte_seen_q;

	// Naive cursor steps: on a hit the cursor advances, on a miss it drops to
	// zero and the byte is not tried again at position zero.
	logic       first_hit;
	logic       second_hit;
	logic       ring_hit;
	logic       carrier_hit;
	logic [3:0] first_adv;
	logic [3:0] second_adv;
	logic [2:0] ring_adv;
	logic [3:0] carrier_adv;

	assign first_hit = (first_cursor_q < flen)
		&& (first_pattern_q[{first_cursor_q[2:0], 3'b000} +: 8] == rx_byte_s1);
	assign second_hit = (second_cursor_q < slen)
		&& (second_pattern_q[{second_cursor_q[2:0], 3'b000} +: 8] == rx_byte_s1);
	assign ring_hit = (ring_cursor_q < atrtpm_pkg::RING_LEN)
		&& (atrtpm_pkg::ring_char(ring_cursor_q[1:0]) == rx_byte_s1);
	assign carrier_hit = (carrier_cursor_q < atrtpm_pkg::CARRIER_LEN)
		&& (atrtpm_pkg::carrier_char(carrier_cursor_q) == rx_byte_s1);

	assign first_adv   = first_hit   ? first_cursor_q + 4'd1   : '0;
	assign second_adv  = second_hit  ? second_cursor_q + 4'd1  : '0;
	assign ring_adv    = ring_hit    ? ring_cursor_q + 3'd1    : '0;
	assign carrier_adv = carrier_hit ? carrier_cursor_q + 4'd1 : '0;

	// Saturating tick counters.
	logic [31:0] elapsed_inc;
	logic [31:0] idle_inc;
	assign elapsed_inc = (&elapsed_ticks_q) ? elapsed_ticks_q : elapsed_ticks_q + 32'd1;
	assign idle_inc    = (&idle_ticks_q) ? idle_ticks_q : idle_ticks_q + 32'd1;

	// Next-state logic. A result ends the session and clears all session state.
	logic        active_n;
	logic [3:0]  first_cursor_n;
	logic        first_found_n;
	logic [3:0]  second_cursor_n;
	logic [2:0]  ring_cursor_n;
	logic [3:0]  carrier_cursor_n;
	logic [31:0] elapsed_ticks_n;
	logic [31:0] idle_ticks_n;
	logic        byte_seen_n;
	logic        done;
	logic [2:0]  outcome_n;

	always_comb begin
		active_n         = active_q;
		first_cursor_n   = first_cursor_q;
		first_found_n    = first_found_q;
		second_cursor_n  = second_cursor_q;
		ring_cursor_n    = ring_cursor_q;
		carrier_cursor_n = carrier_cursor_q;
		elapsed_ticks_n  = elapsed_ticks_q;
		idle_ticks_n     = idle_ticks_q;
		byte_seen_n      = byte_seen_q;
		done             = 1'b0;
		outcome_n        = atrtpm_pkg::OUT_MATCHED;

		if (go) begin
			unique case (cmd_s1)
				atrtpm_pkg::CMD_START: begin
					// A start during a session silently restarts it.
					active_n         = 1'b1;
					first_cursor_n   = '0;
					first_found_n    = 1'b0;
					second_cursor_n  = '0;
					ring_cursor_n    = '0;
					carrier_cursor_n = '0;
					elapsed_ticks_n  = '0;
					idle_ticks_n     = '0;
					byte_seen_n      = 1'b0;
				end
				atrtpm_pkg::CMD_BYTE: begin
					if (active_q) begin
						byte_seen_n  = 1'b1;
						idle_ticks_n = '0;
						// The byte that completes the first pattern is not
						// offered to the second one.
						if (!first_found_q) begin
							if (flen == '0) begin
								first_found_n = 1'b1;
							end else begin
								first_cursor_n = first_adv;
								if (first_adv >= flen) begin
									first_found_n = 1'b1;
								end
							end
						end else if (slen != '0) begin
							second_cursor_n = second_adv;
						end
						// RING wins over NO CARRIER; the latter cursor is left
						// alone when RING completes.
						if (events_enable_q) begin
							ring_cursor_n = ring_adv;
							if (ring_adv >= atrtpm_pkg::RING_LEN) begin
								done      = 1'b1;
								outcome_n = atrtpm_pkg::OUT_RING;
							end else begin
								carrier_cursor_n = carrier_adv;
								if (carrier_adv >= atrtpm_pkg::CARRIER_LEN) begin
									done      = 1'b1;
									outcome_n = atrtpm_pkg::OUT_NO_CARRIER;
								end
							end
						end
						if (!done && first_found_n
								&& (slen == '0 || second_cursor_n >= slen)) begin
							done      = 1'b1;
							outcome_n = atrtpm_pkg::OUT_MATCHED;
						end
					end
				end
				atrtpm_pkg::CMD_TICK: begin
					if (active_q) begin
						elapsed_ticks_n = elapsed_inc;
						// The inter-character timer runs only after the first byte.
						if (byte_seen_q) begin
							idle_ticks_n = idle_inc;
						end
						if (elapsed_inc > full_timeout_q) begin
							done      = 1'b1;
							outcome_n = atrtpm_pkg::OUT_FULL_TIMEOUT;
						end else if (byte_seen_q && idle_inc > char_timeout_q) begin
							done      = 1'b1;
							outcome_n = atrtpm_pkg::OUT_CHAR_TIMEOUT;
						end
					end
				end
				default: ;
			endcase

			if (done) begin
				active_n         = 1'b0;
				first_cursor_n   = '0;
				first_found_n    = 1'b0;
				second_cursor_n  = '0;
				ring_cursor_n    = '0;
				carrier_cursor_n = '0;
				elapsed_ticks_n  = '0;
				idle_ticks_n     = '0;
				byte_seen_n      = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q         <= 1'b0;
			first_cursor_q   <= '0;
			first_found_q    <= 1'b0;
			second_cursor_q  <= '0;
			ring_cursor_q    <= '0;
			carrier_cursor_q <= '0;
			elapsed_ticks_q  <= '0;
			idle_ticks_q     <= '0;
			byte_seen_q      <= 1'b0;
		end else begin
			active_q         <= active_n;
			first_cursor_q   <= first_cursor_n;
			first_found_q    <= first_found_n;
			second_cursor_q  <= second_cursor_n;
			ring_cursor_q    <= ring_cursor_n;
			carrier_cursor_q <= carrier_cursor_n;
			elapsed_ticks_q  <= elapsed_ticks_n;
			idle_ticks_q     <= idle_ticks_n;
			byte_seen_q      <= byte_seen_n;
		end
	end

	// ------------------------------------------------------------------
	// Result register. It holds under result_stall; a finished item is
	// loaded whenever the register is empty or being taken.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (go && done) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && done) begin
			outcome_q <= outcome_n;
		end
	end

	assign result_valid = result_valid_q;
	assign outcome      = outcome_q;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`ASSERT_NEXT(a_done_ends_session, go && done, !active_q && result_valid_q,
		"finished item did not end the session and post a result")
	`ASSERT_ALWAYS(a_idle_counters_clear,
		active_q || (elapsed_ticks_q == '0 && idle_ticks_q == '0 && !byte_seen_q),
		"session counters not clear while no session is active")
	`ASSERT_ALWAYS(a_event_cursor_range,
		ring_cursor_q < atrtpm_pkg::RING_LEN && carrier_cursor_q < atrtpm_pkg::CARRIER_LEN,
		"event cursor left at or beyond its text length")
	`ASSERT_ALWAYS(a_first_cursor_range, first_cursor_q <= MAX_LEN,
		"first pattern cursor beyond the compare window")
	`ASSERT_NEXT(a_stalled_result_kept, result_valid_q && result_stall && !go,
		result_valid_q, "pending result lost under stall")

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

	// Cycles to let pass once nothing is expected any more. This covers items still in flight
	// through the input and result registers that end in no result.
	localparam int SETTLE_CYCLES = 8;
	// Cycles in a row with no item, result or register taken before the run is declared hung.
	localparam int STUCK_LIMIT   = 4000;
	// Items wanted from the random part, counting every item taken, ignored ones included.
	localparam int RANDOM_ITEMS  = 900;

	// The command code that the block ignores.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// The unsolicited texts, first character in the top byte.
	localparam logic [31:0] RING_TEXT    = "RING";
	localparam logic [79:0] CARRIER_TEXT = "NO CARRIER";

	// How a session ended, as the predictor sees it.
	typedef struct packed {
		logic       ended;
		logic [2:0] code;
	} session_end_t;

	// One row of the directed table: either a register write or an item. For an item the
	// expected ending can be typed in; otherwise the predictor supplies it.
	typedef struct packed {
		logic         is_write;
		logic [2:0]   index;
		logic [63:0]  data;
		logic [1:0]   op;
		logic [7:0]   ch;
		logic         known;
		session_end_t want;
	} stim_row_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        cfg_valid    = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index    = '0;
	logic [63:0] cfg_data     = '0;
	logic        item_valid   = 1'b0;
	logic        item_stall;
	logic [1:0]  cmd          = '0;
	logic [7:0]  rx_byte      = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [2:0]  outcome;

	// The ending typed into the directed table travels with the item it belongs to.
	logic         row_known = 1'b0;
	session_end_t row_want  = '0;

	// Register copies, kept in step with every write the block takes.
	logic [63:0] pat_first;
	logic [3:0]  len_first;
	logic [63:0] pat_second;
	logic [3:0]  len_second;
	logic [31:0] to_full;
	logic [31:0] to_char;
	logic        events_on;

	// Session state of the predictor.
	logic        in_session;
	logic [3:0]  first_pos;
	logic        first_done;
	logic [3:0]  second_pos;
	logic [2:0]  ring_pos;
	logic [3:0]  carrier_pos;
	logic [31:0] elapsed;
	logic [31:0] idle_count;
	logic        got_byte;

	// Outcomes predicted but not yet seen on the result channel, oldest first.
	logic [2:0]   expected_outcomes[$];
	stim_row_t    directed_rows[$];
	session_end_t predicted;
	logic [2:0]   oldest;
	int           sent_items       = 0;
	int           errors           = 0;
	int           stuck_cycles     = 0;
	int           item_gap_pct     = 34;
	int           result_stall_pct = 34;

	at_response_two_pattern_matcher i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.cmd          (cmd),
		.rx_byte      (rx_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.outcome      (outcome)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// A length above the pattern store is treated as the full store.
	function automatic logic [3:0] clamp_len(input logic [3:0] len);
		return (len > 4'd8) ? 4'd8 : len;
	endfunction

	// Naive matching: a hit moves the cursor on, a miss drops it to zero and the byte is
	// not compared again.
	function automatic logic [3:0] naive_cursor(input logic [63:0] pat, input logic [3:0] len,
			input logic [3:0] cur, input logic [7:0] b);
		logic [3:0] nxt;
		if (cur < len && cur < 4'd8 && pat[8*cur[2:0] +: 8] == b) begin
			nxt = cur + 4'd1;
		end else begin
			nxt = 4'd0;
		end
		return nxt;
	endfunction

	function automatic void drop_session();
		in_session  = 1'b0;
		first_pos   = '0;
		first_done  = 1'b0;
		second_pos  = '0;
		ring_pos    = '0;
		carrier_pos = '0;
		elapsed     = '0;
		idle_count  = '0;
		got_byte    = 1'b0;
	endfunction

	// Advances the predicted session by one item and tells whether it ended, and how.
	function automatic session_end_t advance_session(input logic [1:0] op, input logic [7:0] b);
		session_end_t res;
		logic [3:0]   flen;
		logic [3:0]   slen;
		logic [2:0]   code;
		logic         done;
		res  = '0;
		code = atrtpm_pkg::OUT_MATCHED;
		done = 1'b0;
		flen = clamp_len(len_first);
		slen = clamp_len(len_second);
		if (op == atrtpm_pkg::CMD_START) begin
			// A start during a session restarts it silently.
			drop_session();
			in_session = 1'b1;
			return res;
		end
		// With no session, and for the unused command code, nothing happens at all.
		if (!in_session || (op != atrtpm_pkg::CMD_BYTE && op != atrtpm_pkg::CMD_TICK)) begin
			return res;
		end
		if (op == atrtpm_pkg::CMD_BYTE) begin
			got_byte   = 1'b1;
			idle_count = '0;
			if (!first_done) begin
				if (flen == 4'd0) begin
					// An empty first pattern is found by whatever byte comes first.
					first_done = 1'b1;
				end else begin
					first_pos = naive_cursor(pat_first, flen, first_pos, b);
					if (first_pos >= flen) begin
						first_done = 1'b1;
					end
				end
			end else if (slen != 4'd0) begin
				// Only bytes after the one that completed the first pattern get here.
				second_pos = naive_cursor(pat_second, slen, second_pos, b);
			end
			if (events_on) begin
				if (RING_TEXT[31 - 8*ring_pos -: 8] == b) begin
					ring_pos = ring_pos + 3'd1;
				end else begin
					ring_pos = 3'd0;
				end
				if (ring_pos == atrtpm_pkg::RING_LEN) begin
					done = 1'b1;
					code = atrtpm_pkg::OUT_RING;
				end else begin
					// The carrier cursor only moves when RING did not just complete.
					if (carrier_pos < atrtpm_pkg::CARRIER_LEN
							&& CARRIER_TEXT[79 - 8*carrier_pos -: 8] == b) begin
						carrier_pos = carrier_pos + 4'd1;
					end else begin
						carrier_pos = 4'd0;
					end
					if (carrier_pos == atrtpm_pkg::CARRIER_LEN) begin
						done = 1'b1;
						code = atrtpm_pkg::OUT_NO_CARRIER;
					end
				end
			end
			if (!done && first_done && (slen == 4'd0 || second_pos >= slen)) begin
				done = 1'b1;
				code = atrtpm_pkg::OUT_MATCHED;
			end
		end else begin
			// Both counters saturate; the character timer only runs once a byte was seen.
			if (elapsed != '1) begin
				elapsed = elapsed + 32'd1;
			end
			if (got_byte && idle_count != '1) begin
				idle_count = idle_count + 32'd1;
			end
			if (elapsed > to_full) begin
				done = 1'b1;
				code = atrtpm_pkg::OUT_FULL_TIMEOUT;
			end else if (got_byte && idle_count > to_char) begin
				done = 1'b1;
				code = atrtpm_pkg::OUT_CHAR_TIMEOUT;
			end
		end
		if (done) begin
			drop_session();
			res.ended = 1'b1;
			res.code  = code;
		end
		return res;
	endfunction

	// Checker. Everything is sampled at the rising edge; the testbench drives on the falling
	// edge, so each handshake seen here is the one the block sees at this same edge. An item
	// is predicted at the edge it is taken, before its result can show up.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					atrtpm_pkg::REG_FIRST_PATTERN:  pat_first  = cfg_data;
					atrtpm_pkg::REG_FIRST_LENGTH:   len_first  = cfg_data[3:0];
					atrtpm_pkg::REG_SECOND_PATTERN: pat_second = cfg_data;
					atrtpm_pkg::REG_SECOND_LENGTH:  len_second = cfg_data[3:0];
					atrtpm_pkg::REG_FULL_TIMEOUT:   to_full    = cfg_data[31:0];
					atrtpm_pkg::REG_CHAR_TIMEOUT:   to_char    = cfg_data[31:0];
					atrtpm_pkg::REG_EVENTS_ENABLE:  events_on  = cfg_data[0];
					default: ;
				endcase
			end
			if (item_valid && !item_stall) begin
				sent_items++;
				predicted = advance_session(cmd, rx_byte);
				if (row_known) begin
					predicted = row_want;
				end
				if (predicted.ended) begin
					expected_outcomes.push_back(predicted.code);
				end
			end
			if (result_valid && !result_stall) begin
				if (expected_outcomes.size() == 0) begin
					$error("outcome: expected no result item, actual %0d", outcome);
					errors++;
				end else begin
					oldest = expected_outcomes.pop_front();
					if (outcome !== oldest) begin
						$error("outcome: expected %0d, actual %0d", oldest, outcome);
						errors++;
					end
				end
			end
		end
	end

	// Hang detector: any cycle in which something is taken resets the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)
					|| (cfg_valid && cfg_ready)) begin
				stuck_cycles <= 0;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// The result side stalls at random, at a rate set per phase.
	always @(negedge clk) begin
		result_stall <= ($urandom_range(0, 99) < result_stall_pct);
	end

	// Offers one item and returns at the falling edge after it was taken. Valid stays high
	// from one item to the next unless a random gap is drawn.
	task automatic send_item(input logic [1:0] op, input logic [7:0] ch, input logic known,
			input session_end_t want);
		while ($urandom_range(0, 99) < item_gap_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		cmd        <= op;
		rx_byte    <= ch;
		row_known  <= known;
		row_want   <= want;
		do @(posedge clk); while (!(item_valid && !item_stall));
		@(negedge clk);
	endtask

	task automatic send_plain(input logic [1:0] op, input logic [7:0] ch);
		send_item(op, ch, 1'b0, '0);
	endtask

	// Writes one register; called only while the block has nothing in hand.
	task automatic write_reg(input logic [2:0] index, input logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Lowers valid, waits for every predicted result and then lets in-flight items drain.
	task automatic settle();
		item_valid <= 1'b0;
		while (expected_outcomes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic row_item(input logic [1:0] op, input logic [7:0] ch);
		directed_rows.push_back('{1'b0, 3'd0, 64'd0, op, ch, 1'b0, session_end_t'('0)});
	endtask

	task automatic row_known_end(input logic [1:0] op, input logic [7:0] ch, input logic ended,
			input logic [2:0] code);
		directed_rows.push_back('{1'b0, 3'd0, 64'd0, op, ch, 1'b1, session_end_t'({ended, code})});
	endtask

	task automatic row_write(input logic [2:0] index, input logic [63:0] data);
		directed_rows.push_back('{1'b1, index, data, atrtpm_pkg::CMD_START, 8'd0, 1'b0,
			session_end_t'('0)});
	endtask

	// Pattern characters lean on a few modem-like bytes so that matches are common.
	function automatic logic [7:0] pick_char();
		logic [7:0] ch;
		case ($urandom_range(0, 5))
			0:       ch = "O";
			1:       ch = "K";
			2:       ch = 8'h0D;
			3:       ch = 8'h0A;
			4:       ch = "R";
			default: ch = 8'($urandom_range(0, 255));
		endcase
		return ch;
	endfunction

	// Sends the first len bytes of a pattern, with an odd tick in between and now and then a
	// corrupted byte.
	task automatic send_pattern(input logic [63:0] pat, input int len);
		logic [7:0] ch;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				send_plain(atrtpm_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
			end
			ch = pat[8*i +: 8];
			if ($urandom_range(0, 11) == 0) begin
				ch = 8'($urandom_range(0, 255));
			end
			send_plain(atrtpm_pkg::CMD_BYTE, ch);
		end
	endtask

	// Draws a full register setting and writes all seven registers. Upper data bits beyond a
	// register's width are filled with junk, which the block must ignore.
	task automatic program_random_setting();
		logic [63:0] pat;
		logic [63:0] junk;
		logic [3:0]  len;
		logic [31:0] limit;
		junk = {$urandom(), $urandom()};
		for (int i = 0; i < 8; i++) pat[8*i +: 8] = pick_char();
		write_reg(atrtpm_pkg::REG_FIRST_PATTERN, pat);
		case ($urandom_range(0, 9))
			0:       len = 4'd0;
			1:       len = 4'd8;
			2:       len = 4'($urandom_range(9, 15));
			default: len = 4'($urandom_range(1, 3));
		endcase
		write_reg(atrtpm_pkg::REG_FIRST_LENGTH, {junk[63:4], len});
		for (int i = 0; i < 8; i++) pat[8*i +: 8] = pick_char();
		write_reg(atrtpm_pkg::REG_SECOND_PATTERN, pat);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: len = 4'd0;
			4:          len = 4'd8;
			5:          len = 4'($urandom_range(9, 15));
			default:    len = 4'($urandom_range(1, 3));
		endcase
		write_reg(atrtpm_pkg::REG_SECOND_LENGTH, {junk[63:4], len});
		case ($urandom_range(0, 7))
			0:       limit = 32'd0;
			1:       limit = '1;
			default: limit = 32'($urandom_range(4, 60));
		endcase
		write_reg(atrtpm_pkg::REG_FULL_TIMEOUT, {junk[63:32], limit});
		case ($urandom_range(0, 7))
			0:       limit = 32'd0;
			1:       limit = '1;
			default: limit = 32'($urandom_range(1, 12));
		endcase
		write_reg(atrtpm_pkg::REG_CHAR_TIMEOUT, {junk[63:32], limit});
		write_reg(atrtpm_pkg::REG_EVENTS_ENABLE, {junk[63:1], 1'($urandom_range(0, 1))});
	endtask

	// One session of random shape. Half are well formed; the rest are timeouts, the
	// unsolicited texts, restarts and plain noise.
	task automatic run_session();
		int kind;
		int flen;
		int slen;
		int part;
		kind = $urandom_range(0, 9);
		flen = int'(clamp_len(len_first));
		slen = int'(clamp_len(len_second));
		part = $urandom_range(0, flen);
		// Leaving out the start now and then sends items at an idle block.
		if ($urandom_range(0, 9) != 0) begin
			send_plain(atrtpm_pkg::CMD_START, 8'($urandom_range(0, 255)));
		end
		if (kind <= 4) begin
			if (flen == 0) begin
				send_plain(atrtpm_pkg::CMD_BYTE, pick_char());
			end
			send_pattern(pat_first, flen);
			send_pattern(pat_second, slen);
			repeat ($urandom_range(0, 3)) begin
				send_plain(atrtpm_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
			end
		end else if (kind == 5) begin
			if ($urandom_range(0, 1) == 1) begin
				send_plain(atrtpm_pkg::CMD_BYTE, pick_char());
			end
			repeat ($urandom_range(1, 70)) begin
				send_plain(atrtpm_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
			end
		end else if (kind == 6) begin
			send_pattern(pat_first, part);
			if ($urandom_range(0, 1) == 1) begin
				for (int i = 0; i < 4; i++) begin
					send_plain(atrtpm_pkg::CMD_BYTE, RING_TEXT[31 - 8*i -: 8]);
				end
			end else begin
				for (int i = 0; i < 10; i++) begin
					send_plain(atrtpm_pkg::CMD_BYTE, CARRIER_TEXT[79 - 8*i -: 8]);
				end
			end
		end else if (kind == 7) begin
			send_pattern(pat_first, part);
			send_plain(atrtpm_pkg::CMD_START, 8'($urandom_range(0, 255)));
			send_pattern(pat_first, flen);
			send_pattern(pat_second, slen);
		end else begin
			repeat ($urandom_range(4, 16)) begin
				send_plain(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		stim_row_t row;
		int        random_base;
		int        phase;

		// The predictor starts from the documented reset values.
		pat_first  = '0;
		len_first  = atrtpm_pkg::FIRST_LENGTH_RST;
		pat_second = '0;
		len_second = atrtpm_pkg::SECOND_LENGTH_RST;
		to_full    = atrtpm_pkg::FULL_TIMEOUT_RST;
		to_char    = atrtpm_pkg::CHAR_TIMEOUT_RST;
		events_on  = 1'b0;
		drop_session();

		// Directed table. Under the reset setting the first pattern is two zero bytes and
		// there is no second pattern, so a session ends on the second zero byte.
		// Idle block: a byte and a tick are dropped.
		row_known_end(atrtpm_pkg::CMD_BYTE, 8'h41, 1'b0, atrtpm_pkg::OUT_MATCHED);
		row_known_end(atrtpm_pkg::CMD_TICK, 8'h00, 1'b0, atrtpm_pkg::OUT_MATCHED);
		row_known_end(atrtpm_pkg::CMD_START, 8'h00, 1'b0, atrtpm_pkg::OUT_MATCHED);
		row_item(atrtpm_pkg::CMD_BYTE, 8'h00);
		// The unused command in the middle of a session does nothing.
		row_known_end(CMD_UNUSED, 8'hFF, 1'b0, atrtpm_pkg::OUT_MATCHED);
		row_known_end(atrtpm_pkg::CMD_BYTE, 8'h00, 1'b1, atrtpm_pkg::OUT_MATCHED);
		// A full timeout of zero ends a session on its first tick.
		row_write(atrtpm_pkg::REG_FULL_TIMEOUT, 64'd0);
		row_item(atrtpm_pkg::CMD_START, 8'h00);
		row_known_end(atrtpm_pkg::CMD_TICK, 8'h00, 1'b1, atrtpm_pkg::OUT_FULL_TIMEOUT);
		// With the full timer out of reach and a zero character timeout, the first tick after
		// a mismatching byte ends the session.
		row_write(atrtpm_pkg::REG_FULL_TIMEOUT, 64'hFFFF_FFFF);
		row_write(atrtpm_pkg::REG_CHAR_TIMEOUT, 64'd0);
		row_item(atrtpm_pkg::CMD_START, 8'h00);
		row_item(atrtpm_pkg::CMD_BYTE, 8'hFF);
		row_known_end(atrtpm_pkg::CMD_TICK, 8'h00, 1'b1, atrtpm_pkg::OUT_CHAR_TIMEOUT);
		// Empty first pattern, an over-long second pattern and the unsolicited texts enabled.
		row_write(atrtpm_pkg::REG_FIRST_LENGTH, 64'd0);
		row_write(atrtpm_pkg::REG_SECOND_LENGTH, 64'd15);
		row_write(atrtpm_pkg::REG_EVENTS_ENABLE, 64'd1);
		row_item(atrtpm_pkg::CMD_START, 8'h00);
		row_item(atrtpm_pkg::CMD_BYTE, "R");
		// A restart drops the partial RING.
		row_item(atrtpm_pkg::CMD_START, 8'h00);
		row_item(atrtpm_pkg::CMD_BYTE, "R");
		row_item(atrtpm_pkg::CMD_BYTE, "I");
		row_item(atrtpm_pkg::CMD_BYTE, "N");
		row_known_end(atrtpm_pkg::CMD_BYTE, "G", 1'b1, atrtpm_pkg::OUT_RING);
		row_item(atrtpm_pkg::CMD_START, 8'h00);
		for (int i = 0; i < 9; i++) row_item(atrtpm_pkg::CMD_BYTE, CARRIER_TEXT[79 - 8*i -: 8]);
		row_known_end(atrtpm_pkg::CMD_BYTE, "R", 1'b1, atrtpm_pkg::OUT_NO_CARRIER);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < directed_rows.size(); i++) begin
			row = directed_rows[i];
			if (row.is_write) begin
				settle();
				write_reg(row.index, row.data);
			end else begin
				send_item(row.op, row.ch, row.known, row.want);
			end
		end

		// Random part: phases of one register setting and a handful of sessions each. Every
		// fifth phase runs with no gaps and no stalls at all.
		random_base = sent_items;
		phase = 0;
		while (sent_items - random_base < RANDOM_ITEMS) begin
			settle();
			program_random_setting();
			item_gap_pct     = (phase % 5 == 2) ? 0 : 34;
			result_stall_pct = item_gap_pct;
			repeat (6) run_session();
			phase++;
		end
		settle();

		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
